// ----- sv/sbb_pkg.sv -----
// Package: shared types and constants of the scaled bitmap blitter.
package sbb_pkg;

  localparam int unsigned BYTE_W     = 8;   // bits per bitmap byte, MSB drawn first
  localparam int unsigned CFG_W      = 16;  // widest configuration register
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned ORIG_W     = 10;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned SYM_W_W    = 6;
  localparam int unsigned SYM_H_W    = 8;
  localparam int unsigned SCALE_W    = 2;
  localparam int unsigned RESULT_CAP = 32;  // pixel writes kept per byte
  localparam int unsigned CAP_W      = $clog2(RESULT_CAP + 1);
  localparam int unsigned BIT_IDX_W  = $clog2(BYTE_W);

  localparam logic [SYM_W_W-1:0] SYM_W_RST = SYM_W_W'(8);
  localparam logic [SYM_H_W-1:0] SYM_H_RST = SYM_H_W'(8);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_SYMBOL_WIDTH  = 3'd2,
    REG_SYMBOL_HEIGHT = 3'd3,
    REG_SCALE_X       = 3'd4,
    REG_SCALE_Y       = 3'd5,
    REG_INK_COLOR     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

endpackage

// ----- sv/scaled_bitmap_blitter_top.sv -----
// Top level: scaled one-bit bitmap blitter, byte in, pixel write requests out.
//
// Bytes of a packed 1-bpp symbol bitmap enter one at a time (bit 7 drawn first,
// bits running on across row ends). Each byte is shifted out bit by bit;
// a set bit turns into scale_x * scale_y pixel write requests at
// origin + scaled position in ink_color, rows of the block first, left to right;
// a clear bit writes nothing. The generator makes one pixel write per cycle
// while the output side does not stall. Generated writes go through a
// one-deep pending stage so the final write of a byte can be tagged
// last_of_byte, then into an output register; a new byte is taken as soon as
// the generator is idle, even while the last write still waits at the output.
// After the final bitmap row the rest of the byte is padding and is dropped.
// Configuration writes are only legal while the block is idle.
module scaled_bitmap_blitter_top #(
  parameter int unsigned MAX_WIDTH  = 32,
  parameter int unsigned MAX_HEIGHT = 128,
  parameter int unsigned MAX_SCALE  = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sbb_pkg::CFG_W-1:0]        cfg_data_i,
  // bitmap byte requests
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sbb_pkg::BYTE_W-1:0]       bitmap_byte_i,
  // pixel write requests
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [sbb_pkg::COORD_W-1:0] pixel_x_o,
  output logic signed [sbb_pkg::COORD_W-1:0] pixel_y_o,
  output logic [sbb_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                             last_of_byte_o
);
  import sbb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);       // column counter
  localparam int unsigned RW = $clog2(MAX_HEIGHT);      // row counter
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int unsigned SW = $clog2(MAX_SCALE + 1);   // effective scale / sub-pixel

  // configuration registers
  logic [ORIG_W-1:0]  ox_q, oy_q;
  logic [SYM_W_W-1:0] sym_w_q;
  logic [SYM_H_W-1:0] sym_h_q;
  logic [SCALE_W-1:0] scl_x_q, scl_y_q;
  logic [COLOR_W-1:0] ink_q;

  // control
  state_e               state_q, state_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [CW-1:0]        col_q, col_d;
  logic [RW-1:0]        row_q, row_d;
  logic [SW-1:0]        xe_q, xe_d, ye_q, ye_d;
  logic [CAP_W-1:0]     n_q, n_d;
  logic                 pend_valid_q, pend_valid_d;
  logic                 out_valid_q, out_valid_d;

  // payload
  logic [BYTE_W-1:0]  sh_q, sh_d;
  logic [COORD_W-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic [COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [COLOR_W-1:0] out_color_q, out_color_d;
  logic               out_last_q, out_last_d;

  // clamped sizes
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [SW-1:0] sx_eff, sy_eff;

  logic               in_acc, out_free, capped, cur_bit;
  logic               xe_last, ye_last, col_end, row_end;
  logic [COORD_W-1:0] px, py;

  always_comb begin
    if (sym_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(sym_w_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(sym_w_q);
    end
    if (sym_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(sym_h_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(sym_h_q);
    end
    if (scl_x_q == '0) begin
      sx_eff = SW'(1);
    end else if (32'(scl_x_q) > MAX_SCALE) begin
      sx_eff = SW'(MAX_SCALE);
    end else begin
      sx_eff = SW'(scl_x_q);
    end
    if (scl_y_q == '0) begin
      sy_eff = SW'(1);
    end else if (32'(scl_y_q) > MAX_SCALE) begin
      sy_eff = SW'(MAX_SCALE);
    end else begin
      sy_eff = SW'(scl_y_q);
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign capped   = (n_q == CAP_W'(RESULT_CAP));
  assign cur_bit  = sh_q[BYTE_W-1];
  assign xe_last  = (xe_q == sx_eff - SW'(1));
  assign ye_last  = (ye_q == sy_eff - SW'(1));
  // a column or row past a shrunk size also ends its row or symbol
  assign col_end  = (WW'(col_q) + WW'(1)) >= w_eff;
  assign row_end  = (HW'(row_q) + HW'(1)) >= h_eff;

  // screen position, wraps at 11 bits
  assign px = {ox_q[ORIG_W-1], ox_q} + COORD_W'(col_q) * COORD_W'(sx_eff) + COORD_W'(xe_q);
  assign py = {oy_q[ORIG_W-1], oy_q} + COORD_W'(row_q) * COORD_W'(sy_eff) + COORD_W'(ye_q);

  // next state and datapath control
  always_comb begin
    logic emit, step_done;
    state_d      = state_q;
    bit_idx_d    = bit_idx_q;
    col_d        = col_q;
    row_d        = row_q;
    xe_d         = xe_q;
    ye_d         = ye_q;
    n_d          = n_q;
    sh_d         = sh_q;
    pend_valid_d = pend_valid_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    emit         = 1'b0;
    step_done    = 1'b0;
    in_stall_o   = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sh_d      = bitmap_byte_i;
          bit_idx_d = '0;
          xe_d      = '0;
          ye_d      = '0;
          n_d       = '0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cur_bit && !capped) begin
          // one write per cycle unless stalled; pending one moves to output
          if (!pend_valid_q || out_free) begin
            emit = 1'b1;
            step_done = xe_last && ye_last;
          end
        end else begin
          step_done = 1'b1;
        end
        if (emit) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_x_d     = pend_x_q;
            out_y_d     = pend_y_q;
            out_color_d = ink_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_x_d     = px;
          pend_y_d     = py;
          n_d          = n_q + CAP_W'(1);
          if (xe_last) begin
            xe_d = '0;
            ye_d = ye_q + SW'(1);
          end else begin
            xe_d = xe_q + SW'(1);
          end
        end
        if (step_done) begin
          xe_d      = '0;
          ye_d      = '0;
          sh_d      = {sh_q[BYTE_W-2:0], 1'b0};
          bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
          if (bit_idx_q == BIT_IDX_W'(BYTE_W - 1)) begin
            state_d = ST_FLUSH;
          end
          if (col_end) begin
            col_d = '0;
            if (row_end) begin
              row_d   = '0;
              state_d = ST_FLUSH;   // rest of the byte is padding
            end else begin
              row_d = row_q + RW'(1);
            end
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_x_d      = pend_x_q;
          out_y_d      = pend_y_q;
          out_color_d  = ink_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bit_idx_q    <= '0;
      col_q        <= '0;
      row_q        <= '0;
      xe_q         <= '0;
      ye_q         <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_idx_q    <= bit_idx_d;
      col_q        <= col_d;
      row_q        <= row_d;
      xe_q         <= xe_d;
      ye_q         <= ye_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q        <= sh_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q    <= '0;
      oy_q    <= '0;
      sym_w_q <= SYM_W_RST;
      sym_h_q <= SYM_H_RST;
      scl_x_q <= SCALE_RST;
      scl_y_q <= SCALE_RST;
      ink_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORIGIN_X:      ox_q    <= cfg_data_i[ORIG_W-1:0];
        REG_ORIGIN_Y:      oy_q    <= cfg_data_i[ORIG_W-1:0];
        REG_SYMBOL_WIDTH:  sym_w_q <= cfg_data_i[SYM_W_W-1:0];
        REG_SYMBOL_HEIGHT: sym_h_q <= cfg_data_i[SYM_H_W-1:0];
        REG_SCALE_X:       scl_x_q <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_Y:       scl_y_q <= cfg_data_i[SCALE_W-1:0];
        REG_INK_COLOR:     ink_q   <= cfg_data_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign pixel_color_o  = out_color_q;
  assign last_of_byte_o = out_last_q;

  // a byte always starts with nothing pending
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending write left over at idle");

  // per-byte write count never passes the cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CAP_W'(RESULT_CAP))
    else $error("write count beyond cap");

  // an accepted byte starts the generator fresh
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN) && (n_q == '0) && (bit_idx_q == '0))
    else $error("byte start not clean");

  // a last-of-byte write leaves the generator idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && pend_valid_q && out_free) |=> out_valid_q && out_last_q
      && (state_q == ST_IDLE))
    else $error("flush did not deliver last write");

endmodule

// ----- tb/sv/scaled_bitmap_blitter_top_tb.sv -----
// Testbench: scaled bitmap blitter, byte requests in, checked pixel write requests out.
module scaled_bitmap_blitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbb_pkg::*;

  localparam int unsigned MAX_WIDTH     = 32;
  localparam int unsigned MAX_HEIGHT    = 128;
  localparam int unsigned MAX_SCALE     = 2;
  localparam int unsigned SETTLE_CYCLES = 40;      // one byte at 2x2, all set, plus output stages
  localparam int unsigned LIMIT_CYCLES  = 400_000;
  localparam int unsigned RANDOM_BYTES  = 400;
  localparam int unsigned IDLE_PCT      = 19;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [CFG_IDX_W-1:0] BAD_REG_IDX = CFG_IDX_W'(7);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_write_t;

  // DUT connections, all inputs known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx     = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    bitmap_byte = '0;
  logic                 out_valid_o;
  logic                 out_stall   = 1'b0;
  logic signed [COORD_W-1:0] pixel_x_o;
  logic signed [COORD_W-1:0] pixel_y_o;
  logic [COLOR_W-1:0]   pixel_color_o;
  logic                 last_of_byte_o;

  // register mirror and bitmap position of the predictor
  logic [ORIG_W-1:0]  org_x   = '0;
  logic [ORIG_W-1:0]  org_y   = '0;
  logic [SYM_W_W-1:0] sym_w   = SYM_W_RST;
  logic [SYM_H_W-1:0] sym_h   = SYM_H_RST;
  logic [SCALE_W-1:0] scl_x   = SCALE_RST;
  logic [SCALE_W-1:0] scl_y   = SCALE_RST;
  logic [COLOR_W-1:0] ink     = '0;
  logic [4:0]         col_pos = '0;
  logic [6:0]         row_pos = '0;

  logic [BYTE_W-1:0] pending_bytes[$];
  pixel_write_t      pixel_q[$];       // pixel writes still owed by the block
  bit                byte_taken  = 1'b0;
  bit                idle_on     = 1'b1;
  int unsigned       hold_left   = 0;
  int unsigned       fail_count  = 0;

  scaled_bitmap_blitter_top #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_SCALE (MAX_SCALE)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .bitmap_byte_i (bitmap_byte),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_of_byte_o(last_of_byte_o)
  );

  always #1 clk_i = ~clk_i;

  // zero acts as one, anything past the limit acts as the limit
  function automatic int unsigned fold(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic bit coin(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Expand one byte into its pixel writes: MSB first, each set bit becomes a
  // scale_x by scale_y block, rows of the block first. The symbol ends after
  // the last row and the rest of the byte is padding.
  task automatic draw_byte(input logic [BYTE_W-1:0] bits);
    int unsigned  w, h, sx, sy, n;
    int           ox, oy;
    pixel_write_t held;
    bit           have_held;
    w  = fold(sym_w, MAX_WIDTH);
    h  = fold(sym_h, MAX_HEIGHT);
    sx = fold(scl_x, MAX_SCALE);
    sy = fold(scl_y, MAX_SCALE);
    ox = int'($signed(org_x));
    oy = int'($signed(org_y));
    n  = 0;
    have_held = 1'b0;
    held = '0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (bits[b]) begin
        for (int unsigned ye = 0; ye < sy; ye++) begin
          for (int unsigned xe = 0; xe < sx; xe++) begin
            if (n < RESULT_CAP) begin
              if (have_held) pixel_q.push_back(held);
              held.x     = COORD_W'(ox + int'(col_pos * sx + xe));
              held.y     = COORD_W'(oy + int'(row_pos * sy + ye));
              held.color = ink;
              held.last  = 1'b0;
              have_held  = 1'b1;
              n++;
            end
          end
        end
      end
      if (col_pos + 1 >= w) begin
        col_pos = '0;
        if (row_pos + 1 >= h) begin
          row_pos = '0;
          break;
        end
        row_pos++;
      end else begin
        col_pos++;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pixel_q.push_back(held);
    end
  endtask

  // Request side: hold a byte until taken, then offer the next one unless idling.
  always @(negedge clk_i) begin : byte_driver
    logic              nxt_valid;
    logic [BYTE_W-1:0] nxt_byte;
    nxt_valid = in_valid;
    nxt_byte  = bitmap_byte;
    if (byte_taken) begin
      nxt_valid  = 1'b0;
      byte_taken = 1'b0;
    end
    if (!nxt_valid && pending_bytes.size() != 0 && !(idle_on && coin(IDLE_PCT))) begin
      nxt_byte  = pending_bytes.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid    <= nxt_valid;
    bitmap_byte <= nxt_byte;
  end

  // Pixel side: random stalls, or a long hold-off counted down here.
  always @(negedge clk_i) begin : stall_driver
    logic nxt_stall;
    if (hold_left != 0) begin
      nxt_stall = 1'b1;
      hold_left--;
    end else begin
      nxt_stall = idle_on && coin(IDLE_PCT);
    end
    out_stall <= nxt_stall;
  end

  // Both handshakes are sampled here; prediction happens on byte acceptance.
  always @(posedge clk_i) begin : pixel_monitor
    pixel_write_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        draw_byte(bitmap_byte);
        byte_taken = 1'b1;
      end
      if (out_valid_o && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("write to (%0d,%0d) with none expected",
                                    pixel_x_o, pixel_y_o));
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x_o !== want.x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                      pixel_x_o, $signed(want.x)));
          if (pixel_y_o !== want.y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                      pixel_y_o, $signed(want.y)));
          if (pixel_color_o !== want.color)
            report_mismatch($sformatf("pixel_color %h, expected %h",
                                      pixel_color_o, want.color));
          if (last_of_byte_o !== want.last)
            report_mismatch($sformatf("last_of_byte %b, expected %b",
                                      last_of_byte_o, want.last));
        end
      end
    end
  end

  // Register write, only while the block is idle; returns at a rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_ORIGIN_X:      org_x = data[ORIG_W-1:0];
      REG_ORIGIN_Y:      org_y = data[ORIG_W-1:0];
      REG_SYMBOL_WIDTH:  sym_w = data[SYM_W_W-1:0];
      REG_SYMBOL_HEIGHT: sym_h = data[SYM_H_W-1:0];
      REG_SCALE_X:       scl_x = data[SCALE_W-1:0];
      REG_SCALE_Y:       scl_y = data[SCALE_W-1:0];
      REG_INK_COLOR:     ink   = data[COLOR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every byte is taken and every write is seen, then let any
  // trailing clear bits or padding work through before touching registers.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || pixel_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] random_bitmap_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'hFF;
    if (r < 30) return 8'h00;
    if (r < 40) return 8'h80 >> $urandom_range(BYTE_W - 1);
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] random_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 16) return CFG_W'($urandom_range(33, 63));
    if (r < 22) return CFG_W'($urandom);           // upper bits are don't-care
    if (r < 30) return CFG_W'(MAX_WIDTH);
    return CFG_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [CFG_W-1:0] random_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6)  return '0;
    if (r < 12) return CFG_W'($urandom_range(129, 255));
    if (r < 16) return CFG_W'(MAX_HEIGHT);
    return CFG_W'($urandom_range(1, 10));
  endfunction

  function automatic logic [CFG_W-1:0] random_scale();
    if (coin(30)) return CFG_W'($urandom);       // covers 0 and 3 plus junk
    return CFG_W'($urandom_range(1, MAX_SCALE));
  endfunction

  function automatic logic [CFG_W-1:0] random_origin();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return CFG_W'(16'h0200);           // most negative
    if (r < 20) return CFG_W'(16'h01FF);           // most positive
    return CFG_W'($urandom);
  endfunction

  initial begin : stimulus
    int unsigned random_items;
    int unsigned phase;
    int unsigned per_symbol;
    int unsigned n;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // reset settings: 8x8 unscaled at the origin, black ink
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(8'h01);
    wait_drained();

    // zero width/height/scale_x, oversized scale_y, extreme origins, junk in
    // upper data bits, an out-of-range index; the row counter is still at 4,
    // past the new height, so the symbol ends at the first advance
    write_reg(REG_ORIGIN_X, 16'hFE00);
    write_reg(REG_ORIGIN_Y, 16'h01FF);
    write_reg(REG_SYMBOL_WIDTH, 16'h0000);
    write_reg(REG_SYMBOL_HEIGHT, 16'h0000);
    write_reg(REG_SCALE_X, 16'h0000);
    write_reg(REG_SCALE_Y, 16'h0003);
    write_reg(REG_INK_COLOR, 16'hFFFF);
    write_reg(BAD_REG_IDX, 16'h1234);
    pending_bytes.push_back(8'hAA);
    pending_bytes.push_back(8'h55);
    wait_drained();

    // oversized width/height clamp to the maxima; reach the last column
    write_reg(REG_SYMBOL_WIDTH, 16'hFFFF);
    write_reg(REG_SYMBOL_HEIGHT, 16'h00FF);
    write_reg(REG_SCALE_X, 16'h0003);
    write_reg(REG_SCALE_Y, 16'h0001);
    write_reg(REG_ORIGIN_X, 16'h01FF);
    write_reg(REG_ORIGIN_Y, 16'h0200);
    write_reg(REG_INK_COLOR, 16'h8001);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h0F);
    pending_bytes.push_back(8'hF0);
    wait_drained();

    // full bytes at 2x2: the most writes one byte can cause
    write_reg(REG_SYMBOL_WIDTH, 16'd32);
    write_reg(REG_SYMBOL_HEIGHT, 16'd128);
    write_reg(REG_SCALE_X, 16'd2);
    write_reg(REG_SCALE_Y, 16'd2);
    write_reg(REG_ORIGIN_X, 16'h0000);
    write_reg(REG_ORIGIN_Y, 16'h0000);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    wait_drained();

    // shrink mid-symbol (column 16 of a 3-wide symbol), then padding drops
    write_reg(REG_SYMBOL_WIDTH, 16'd3);
    write_reg(REG_SYMBOL_HEIGHT, 16'd2);
    write_reg(REG_SCALE_X, 16'd1);
    write_reg(REG_SCALE_Y, 16'd1);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFC);
    wait_drained();

    // 15-bit symbol: second byte leaves one padding bit
    write_reg(REG_SYMBOL_WIDTH, 16'd5);
    write_reg(REG_SYMBOL_HEIGHT, 16'd3);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h01);
    wait_drained();

    // --- random part: mostly whole symbols under random settings ---
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_BYTES) begin
      idle_on = !(phase >= 3 && phase <= 6);   // a stretch with no idling at all
      if (coin(70)) write_reg(REG_ORIGIN_X, random_origin());
      if (coin(70)) write_reg(REG_ORIGIN_Y, random_origin());
      if (coin(70)) write_reg(REG_SYMBOL_WIDTH, random_width());
      if (coin(70)) write_reg(REG_SYMBOL_HEIGHT, random_height());
      if (coin(60)) write_reg(REG_SCALE_X, random_scale());
      if (coin(60)) write_reg(REG_SCALE_Y, random_scale());
      if (coin(70)) write_reg(REG_INK_COLOR, CFG_W'($urandom));
      if (coin(5))  write_reg(BAD_REG_IDX, CFG_W'($urandom));

      if (phase == 8) begin
        // output held off for a long time while full bytes keep coming
        write_reg(REG_SCALE_X, 16'd2);
        write_reg(REG_SCALE_Y, 16'd2);
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 30; i++) pending_bytes.push_back(8'hFF);
        random_items += 30;
      end else begin
        per_symbol = (fold(sym_w, MAX_WIDTH) * fold(sym_h, MAX_HEIGHT) + 7) / 8;
        if (coin(15)) n = $urandom_range(1, 8);            // partial or broken symbol
        else          n = per_symbol * $urandom_range(1, 2);
        if (n > 24) n = 24;
        for (int i = 0; i < n; i++) pending_bytes.push_back(random_bitmap_byte());
        random_items += n;
      end
      wait_drained();
      phase++;
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
